@@ sv/ifm_pkg.sv @@
// ----------------------------------------------------------------------------
// ifm_pkg: shared types and constants
// Field widths, register indexes, reset values and the handshake status
// record of the input capture frequency meter.
// ----------------------------------------------------------------------------
`default_nettype none

package ifm_pkg;

  localparam int unsigned CapW    = 16;  // capture_value field
  localparam int unsigned PeriodW = 16;  // timer_period register
  localparam int unsigned ClockW  = 28;  // clock_hz register, the dividend
  localparam int unsigned CfgW    = 28;  // widest register
  localparam int unsigned SpanW   = 32;  // span in counts
  localparam int unsigned FreqW   = 32;  // frequency field

  localparam logic [PeriodW-1:0] RstTimerPeriod = 16'd65535;
  localparam logic [ClockW-1:0]  RstClockHz     = 28'd84000000;

  typedef enum logic [0:0] {
    RegTimerPeriod = 1'b0,
    RegClockHz     = 1'b1
  } reg_idx_e;

  typedef enum logic [0:0] {
    OpTick    = 1'b0,
    OpCapture = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StDiv  = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

endpackage

`default_nettype wire

@@ sv/ifm_in_if.sv @@
// ----------------------------------------------------------------------------
// ifm_in_if: input item channel
// Valid/ready channel carrying one overflow tick or capture event.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifm_in_if;
  import ifm_pkg::*;

  logic                valid;
  logic                ready;
  logic                opcode;
  logic [CapW-1:0]     capture_value;

  modport source (output valid, output opcode, output capture_value, input ready);
  modport sink   (input valid, input opcode, input capture_value, output ready);
endinterface

`default_nettype wire

@@ sv/ifm_out_if.sv @@
// ----------------------------------------------------------------------------
// ifm_out_if: result channel
// Valid/ready channel carrying one frequency measurement.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifm_out_if;
  import ifm_pkg::*;

  logic                valid;
  logic                ready;
  logic [FreqW-1:0]    frequency;
  logic                zero_span;

  modport source (output valid, output frequency, output zero_span, input ready);
  modport sink   (input valid, input frequency, input zero_span, output ready);
endinterface

`default_nettype wire

@@ sv/ifm_mul.sv @@
// ----------------------------------------------------------------------------
// ifm_mul: bit-serial span accumulator
// Computes base + mult * mcand modulo 2^32, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ifm_mul #(
  parameter int unsigned MultW = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [ifm_pkg::SpanW-1:0]   base_i,
  input  wire logic [MultW-1:0]            mult_i,
  input  wire logic [ifm_pkg::PeriodW-1:0] mcand_i,
  output      ifm_pkg::unit_st_t           st_o,
  output      logic [ifm_pkg::SpanW-1:0]   span_o
);
  import ifm_pkg::*;

  localparam int unsigned CntW = (MultW > 1) ? $clog2(MultW) : 1;

  logic [SpanW-1:0] acc_q, acc_d;
  logic [SpanW-1:0] mcand_q, mcand_d;
  logic [MultW-1:0] mult_q, mult_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             last;

  assign last = (cnt_q == CntW'(MultW - 1));

  always_comb begin
    acc_d   = acc_q;
    mcand_d = mcand_q;
    mult_d  = mult_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      acc_d   = base_i;
      mcand_d = SpanW'(mcand_i);
      mult_d  = mult_i;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (mult_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d = {mcand_q[SpanW-2:0], 1'b0};
      mult_d  = mult_q >> 1;
      cnt_d   = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    mult_q  <= mult_d;
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign span_o    = acc_q;

endmodule

`default_nettype wire

@@ sv/ifm_div.sv @@
// ----------------------------------------------------------------------------
// ifm_div: radix-2 restoring divider
// Divides the 28-bit clock frequency by a nonzero 32-bit span, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ifm_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [ifm_pkg::ClockW-1:0] dividend_i,
  input  wire logic [ifm_pkg::SpanW-1:0]  divisor_i,
  output      ifm_pkg::unit_st_t          st_o,
  output      logic [ifm_pkg::ClockW-1:0] quotient_o
);
  import ifm_pkg::*;

  localparam int unsigned CntW = $clog2(ClockW);

  logic [SpanW-1:0]  rem_q, rem_d;
  logic [SpanW-1:0]  dvs_q, dvs_d;
  logic [ClockW-1:0] quo_q, quo_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SpanW:0]    shifted;
  logic [SpanW:0]    trial;
  logic              borrow;

  assign shifted = {rem_q, quo_q[ClockW-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign borrow  = trial[SpanW];

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low word holds it
      rem_d = borrow ? shifted[SpanW-1:0] : trial[SpanW-1:0];
      quo_d = {quo_q[ClockW-2:0], ~borrow};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(ClockW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign st_o.busy  = busy_q;
  assign st_o.done  = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ sv/input_capture_frequency_meter_core.sv @@
// ----------------------------------------------------------------------------
// input_capture_frequency_meter_core: reciprocal frequency meter
// Measures the span between two timer captures and reports clock_hz / span.
// ----------------------------------------------------------------------------
// An overflow tick or a first capture yields no result. A second capture
// yields one result after the bit-serial span multiply, the restoring
// divider and the output state; a zero span skips the divider. No new
// item is taken while a measurement is running, and a finished result waits
// in the output register without holding off the next item until a second
// result is ready behind it.
`default_nettype none

module input_capture_frequency_meter_core #(
  parameter int unsigned COUNTER_WIDTH  = 16,
  parameter int unsigned OVERFLOW_WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire ifm_pkg::reg_idx_e        cfg_index_i,
  input  wire logic [ifm_pkg::CfgW-1:0] cfg_data_i,
  ifm_in_if.sink                        in_ch,
  ifm_out_if.source                     out_ch
);
  import ifm_pkg::*;

  localparam int unsigned CntrW = (COUNTER_WIDTH < CapW) ? COUNTER_WIDTH : CapW;

  state_e                  state_q, state_d;
  logic [PeriodW-1:0]      period_q;
  logic [ClockW-1:0]       clock_q;
  logic                    armed_q, armed_d;
  logic [OVERFLOW_WIDTH-1:0] ovf_q, ovf_d;
  logic [CntrW-1:0]        first_q, first_d;
  logic [FreqW-1:0]        res_freq_q, res_freq_d;
  logic                    res_zero_q, res_zero_d;
  logic                    out_valid_q, out_valid_d;
  logic [FreqW-1:0]        out_freq_q;
  logic                    out_zero_q;
  logic                    in_xfer;
  logic                    out_load;
  logic                    mul_start;
  logic                    div_start;
  logic [CntrW-1:0]        cap;
  logic [SpanW-1:0]        base;
  logic [SpanW-1:0]        span;
  logic [ClockW-1:0]       quotient;
  unit_st_t                mul_st;
  unit_st_t                div_st;

  assign in_ch.ready = (state_q == StIdle);
  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign cap         = in_ch.capture_value[CntrW-1:0];
  assign base        = SpanW'(cap) - SpanW'(first_q);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= RstTimerPeriod;
      clock_q  <= RstClockHz;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegTimerPeriod: period_q <= cfg_data_i[PeriodW-1:0];
        RegClockHz:     clock_q  <= cfg_data_i[ClockW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    armed_d     = armed_q;
    ovf_d       = ovf_q;
    first_d     = first_q;
    res_freq_d  = res_freq_q;
    res_zero_d  = res_zero_q;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q;
    if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (in_ch.opcode == OpTick) begin
            ovf_d = ovf_q + 1'b1;
          end else if (!armed_q) begin
            ovf_d   = '0;
            first_d = cap;
            armed_d = 1'b1;
          end else begin
            armed_d   = 1'b0;
            mul_start = 1'b1;
            state_d   = StMul;
          end
        end
      end
      StMul: begin
        if (mul_st.done) begin
          if (span == '0) begin
            res_freq_d = '0;
            res_zero_d = 1'b1;
            state_d    = StOut;
          end else begin
            div_start = 1'b1;
            state_d   = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_st.done) begin
          res_freq_d = FreqW'(quotient);
          res_zero_d = 1'b0;
          state_d    = StOut;
        end
      end
      StOut: begin
        // hold until the output register is free
        if (!out_valid_q || out_ch.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      armed_q     <= 1'b0;
      ovf_q       <= '0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      ovf_q       <= ovf_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_freq_q <= res_freq_d;
    res_zero_q <= res_zero_d;
    if (out_load) begin
      out_freq_q <= res_freq_q;
      out_zero_q <= res_zero_q;
    end
  end

  ifm_mul #(
    .MultW (OVERFLOW_WIDTH)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .base_i  (base),
    .mult_i  (ovf_q),
    .mcand_i (period_q),
    .st_o    (mul_st),
    .span_o  (span)
  );

  ifm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (clock_q),
    .divisor_i  (span),
    .st_o       (div_st),
    .quotient_o (quotient)
  );

  assign out_ch.valid     = out_valid_q;
  assign out_ch.frequency = out_freq_q;
  assign out_ch.zero_span = out_zero_q;

`ifndef NO_ASSERTIONS
  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_st.done |-> state_q == StMul)
    else $error("span unit finished outside its phase");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == StDiv)
    else $error("divider finished outside its phase");

  a_units_busy_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_st.busy || div_st.busy) |-> state_q != StIdle)
    else $error("arithmetic unit busy while taking items");

  a_zero_span_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.zero_span) |-> out_ch.frequency == '0)
    else $error("zero span reported with nonzero frequency");

  a_second_capture_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_ch.opcode == OpCapture && armed_q) |=> (!armed_q && state_q == StMul))
    else $error("second capture did not start a measurement");
`endif

endmodule

`default_nettype wire

@@ test/input_capture_frequency_meter_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// input_capture_frequency_meter_core_test: self-checking testbench
// Drives overflow ticks and capture events through bursty valid/ready traffic
// and checks every frequency result against an in-bench model of the meter.
// Runs a directed opening, then random capture pairs under several period and
// clock settings.
// ----------------------------------------------------------------------------

module input_capture_frequency_meter_core_test;
  import ifm_pkg::*;

  localparam int unsigned OvfW      = 8;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseLen  = 175;
  localparam int unsigned SettleCyc = 50;

  typedef struct packed {
    opcode_e             op;
    logic [CapW-1:0]     cap;
  } timer_event_t;

  typedef struct packed {
    logic [FreqW-1:0]    freq;
    logic                zero;
  } freq_meas_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  reg_idx_e            cfg_index;
  logic [CfgW-1:0]     cfg_data;

  ifm_in_if  in_ch ();
  ifm_out_if out_ch ();

  input_capture_frequency_meter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Meter model state and its copy of the registers
  logic                armed;
  logic [OvfW-1:0]     ovf_cnt;
  logic [CapW-1:0]     first_cap;
  logic [PeriodW-1:0]  period_reg;
  logic [ClockW-1:0]   clock_reg;

  timer_event_t        event_q[$];
  freq_meas_t          owed_q[$];
  int unsigned         queued_n;
  logic                gen_armed;
  logic                failed;
  int                  burst_left;
  int                  gap_left;
  int                  stall_left;
  int                  stall_mode;
  int unsigned         stall_cnt;

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = RegTimerPeriod;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OpTick;
    in_ch.capture_value = '0;
    out_ch.ready      = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_500_000;
    $display("[input_capture_frequency_meter_core] ERROR");
    $finish;
  end

  task automatic meter_step(opcode_e op, logic [CapW-1:0] cap);
    logic [SpanW-1:0] span;
    freq_meas_t       m;
    if (op == OpTick) begin
      ovf_cnt = ovf_cnt + 1'b1;
    end else if (!armed) begin
      ovf_cnt   = '0;
      first_cap = cap;
      armed     = 1'b1;
    end else begin
      span = SpanW'(cap) + SpanW'(ovf_cnt) * SpanW'(period_reg) - SpanW'(first_cap);
      m.zero = (span == '0);
      m.freq = m.zero ? '0 : FreqW'(clock_reg) / span;
      armed  = 1'b0;
      owed_q.push_back(m);
    end
  endtask

  task automatic push_ticks(int n);
    timer_event_t ev;
    ev.op  = OpTick;
    ev.cap = CapW'($urandom());
    repeat (n) begin
      event_q.push_back(ev);
      queued_n++;
    end
  endtask

  task automatic push_capture(logic [CapW-1:0] cap);
    timer_event_t ev;
    ev.op  = OpCapture;
    ev.cap = cap;
    event_q.push_back(ev);
    queued_n++;
    gen_armed = !gen_armed;
  endtask

  // Mostly well-formed capture pairs; the rest are lone captures and stray ticks.
  task automatic queue_random_run();
    int               r;
    int               n;
    logic [CapW-1:0]  c1;
    logic [CapW-1:0]  c2;
    r = $urandom_range(0, 99);
    if (r < 82) begin
      if (gen_armed) push_capture(CapW'($urandom()));
      if ($urandom_range(0, 9) == 0) push_ticks($urandom_range(1, 3));
      c1 = CapW'($urandom());
      r = $urandom_range(0, 199);
      if (r == 0) n = $urandom_range(250, 260);
      else if (r < 110) n = $urandom_range(0, 1);
      else if (r < 170) n = $urandom_range(2, 5);
      else n = $urandom_range(6, 20);
      case ($urandom_range(0, 9))
        0, 1: c2 = c1 + CapW'($urandom_range(0, 3));
        2: c2 = c1;
        3: c2 = c1 - CapW'($urandom_range(1, 3));
        4: c2 = c1 - CapW'(n * period_reg);
        default: c2 = CapW'($urandom());
      endcase
      push_capture(c1);
      push_ticks(n);
      push_capture(c2);
    end else if (r < 92) begin
      push_capture(CapW'($urandom()));
    end else begin
      push_ticks($urandom_range(1, 3));
    end
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == RegTimerPeriod) period_reg = PeriodW'(data);
    else clock_reg = ClockW'(data);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued event is in and every measurement is back,
  // then let a trailing tick or first capture finish.
  task automatic wait_drained();
    while (event_q.size() != 0 || in_ch.valid || owed_q.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    timer_event_t ev;
    int           r;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      burst_left  = 0;
      gap_left    = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        meter_step(opcode_e'(in_ch.opcode), in_ch.capture_value);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (event_q.size() != 0) begin
          ev = event_q.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.opcode        <= ev.op;
          in_ch.capture_value <= ev.cap;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            r = $urandom_range(0, 9);
            if (r < 4) gap_left = 0;
            else if (r < 8) gap_left = $urandom_range(1, 4);
            else if (r == 8) gap_left = $urandom_range(5, 15);
            else gap_left = $urandom_range(16, 48);
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switch at random between four stall patterns
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left   = 0;
      stall_cnt    = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(30, 200);
      end else begin
        stall_left--;
      end
      stall_cnt++;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 7) == 0);
        default: out_ch.ready <= (stall_cnt % 3 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    freq_meas_t m;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (owed_q.size() == 0) begin
        $display("%0t: result with none pending: expected nothing, got frequency=%0d zero_span=%0b",
                 $time, out_ch.frequency, out_ch.zero_span);
        failed = 1'b1;
      end else begin
        m = owed_q.pop_front();
        if (out_ch.frequency !== m.freq) begin
          $display("%0t: frequency mismatch: expected %0d, got %0d",
                   $time, m.freq, out_ch.frequency);
          failed = 1'b1;
        end
        if (out_ch.zero_span !== m.zero) begin
          $display("%0t: zero_span mismatch: expected %0b, got %0b",
                   $time, m.zero, out_ch.zero_span);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    logic [PeriodW-1:0] nper;
    logic [ClockW-1:0]  nclk;
    int unsigned        target;
    failed     = 1'b0;
    armed      = 1'b0;
    ovf_cnt    = '0;
    first_cap  = '0;
    period_reg = RstTimerPeriod;
    clock_reg  = RstClockHz;
    queued_n   = 0;
    gen_armed  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening at the reset settings
    push_ticks(2);                // ticks before any capture
    push_capture(16'h0000);
    push_capture(16'hFFFF);       // full counter span, no overflow
    push_capture(16'hFFFF);
    push_capture(16'h0000);       // span wraps below zero
    push_capture(16'd1234);
    push_capture(16'd1234);       // zero span
    push_capture(16'd10);
    push_ticks(2);
    push_capture(16'd20);         // span across two overflows
    push_capture(16'd5);
    push_capture(16'd6);          // span of one count
    push_capture(16'hAAAA);
    push_ticks(1);
    push_capture(16'h5555);
    push_ticks(3);                // ticks after a measurement
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin nper = '0;           nclk = 28'd200000000; end
        1: begin nper = 16'd1;        nclk = 28'd1;         end
        2: begin nper = 16'hFFFF;     nclk = 28'hFFFFFFF;   end
        3: begin nper = 16'd1000;     nclk = '0;            end
        default: begin
          nper = ($urandom_range(0, 3) == 0) ? PeriodW'($urandom_range(0, 15))
                                             : PeriodW'($urandom());
          nclk = ClockW'($urandom_range(1, 200000000));
        end
      endcase
      write_reg(RegTimerPeriod, CfgW'(nper));
      write_reg(RegClockHz, CfgW'(nclk));

      push_capture(16'd100);
      push_capture(16'd101);
      push_capture(16'd7);
      push_capture(16'd7);
      push_capture(16'd7);
      push_ticks(1);
      push_capture(16'd7);        // zero span only when the period is zero
      if (p == 2) begin
        // overflow count wraps back to zero after 256 ticks
        push_capture(16'd0);
        push_ticks(256);
        push_capture(16'd1);
      end
      target = queued_n + PhaseLen;
      while (queued_n < target) queue_random_run();
      if (gen_armed) push_capture(CapW'($urandom()));
      wait_drained();
    end

    if (!failed)
      $display("[input_capture_frequency_meter_core] OK");
    else
      $display("[input_capture_frequency_meter_core] ERROR");
    $finish;
  end

endmodule
